@@ rtl/bnfs_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and register codes of the band noise floor suppressor.
package bnfs_pkg;

	localparam int SAMPLE_WIDTH_DEF = 24;
	localparam int COEFF_WIDTH_DEF  = 16;

	// internal number formats
	localparam int LP_W    = 32;   // lowpass state, Q1.31
	localparam int POWER_W = 48;   // power and floor, Q2.46
	localparam int HALF_W  = 24;   // split point of the power word for the multiplier
	localparam int WIN_W   = 16;
	localparam int GAIN_BITS = 16;

	// shared multiplier: operand A carries 33-bit differences and band values
	localparam int MUL_A_W = 34;

	localparam logic [POWER_W-1:0] FLOOR_RESET = 48'd70368744;  // about 1e-6
	localparam logic [POWER_W-1:0] POWER_EPS   = 48'd70369;     // about 1e-9

	// register reset values
	localparam logic [23:0] LOW_COEFF_RESET  = 24'd1014;
	localparam logic [23:0] HIGH_COEFF_RESET = 24'd1672;
	localparam logic [23:0] PWR_DECAY_RESET  = 24'd65400;
	localparam logic [23:0] FLR_DECAY_RESET  = 24'd65529;
	localparam logic [WIN_W-1:0] WIN_LEN_RESET = 16'd4800;

	// register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_COEFF  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_COEFF = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PWR_DECAY  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FLR_DECAY  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN    = 3'd4;

endpackage

@@ rtl/bandpass_noise_floor_suppressor.sv @@
`timescale 1ns / 1ps
// Top level of the band noise floor suppressor: sequencer, state and ports.
//
// One signed sample goes in per item and one suppressed band sample comes out.
// Two one-pole lowpasses run on the input and their difference is the band
// signal; its square is smoothed into a power estimate, a noise floor follows
// the power minimum and relaxes toward the power every window_length samples,
// and the band sample is scaled by the gain (power - floor) / (power + eps).
// All products go through one shared registered multiplier and the gain comes
// from a 16-step restoring divider. An item passes the two lowpass updates,
// the band and its square, the power mix, the floor step, the floor mix when
// the floor relaxes on that sample, the divider and the output product, and
// the sequencer then returns to idle. The block
// takes no new item while one is in work, but a finished result waits in the
// output register while the next item is accepted. Configuration writes are
// always taken (cfg_ready is tied high) and must only happen while idle;
// an index past the last register is ignored.
module bandpass_noise_floor_suppressor #(
	parameter int SAMPLE_WIDTH = bnfs_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEFF_WIDTH  = bnfs_pkg::COEFF_WIDTH_DEF,
	localparam int TD_W   = ((SAMPLE_WIDTH + 7) / 8) * 8,
	localparam int CFG_DW = (COEFF_WIDTH > bnfs_pkg::WIN_W) ? COEFF_WIDTH : bnfs_pkg::WIN_W
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [TD_W-1:0]                 s_tdata,    // [SW-1:0] sample_in
	// output stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [TD_W-1:0]                 m_tdata,    // [SW-1:0] sample_out
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bnfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DW-1:0]               cfg_data
);

	localparam int LP_W    = bnfs_pkg::LP_W;
	localparam int POWER_W = bnfs_pkg::POWER_W;
	localparam int HALF_W  = bnfs_pkg::HALF_W;
	localparam int WIN_W   = bnfs_pkg::WIN_W;
	localparam int GAIN_BITS = bnfs_pkg::GAIN_BITS;
	localparam int BAND_W  = LP_W + 1;             // lp difference, Q2.31
	localparam int B23_W   = BAND_W - 8;           // band after the 8-bit floor shift
	localparam int A_W     = bnfs_pkg::MUL_A_W;
	localparam int B_W     = (COEFF_WIDTH + 2 > B23_W) ? COEFF_WIDTH + 2 : B23_W;
	localparam int P_W     = A_W + B_W;
	localparam int ACC_W   = POWER_W + 2;
	localparam int DEN_W   = POWER_W + 1;
	localparam int SUM_W   = LP_W + 3;
	localparam int DCNT_W  = $clog2(GAIN_BITS);
	localparam int OUT_SH  = GAIN_BITS + LP_W - SAMPLE_WIDTH;

	localparam logic signed [SUM_W-1:0] LP_MAX = (SUM_W'(1) <<< (LP_W - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] LP_MIN = ~LP_MAX;
	localparam logic signed [P_W-1:0]   Y_MAX  = (P_W'(1) <<< (SAMPLE_WIDTH - 1)) - P_W'(1);
	localparam logic signed [P_W-1:0]   Y_MIN  = ~Y_MAX;
	localparam logic [COEFF_WIDTH:0]    C_ONE  = (COEFF_WIDTH + 1)'(1) << COEFF_WIDTH;

	typedef enum logic [3:0] {
		S_IDLE, S_LP1M, S_LP1A, S_LP2M, S_LP2A, S_BAND, S_SQM, S_SQA,
		S_MIXM, S_MIXA, S_MIXE, S_FLOOR, S_DIVI, S_DIV, S_OUTM, S_OUTA
	} state_t;

	// configuration registers
	logic [COEFF_WIDTH-1:0] low_coeff_q, high_coeff_q, pwr_decay_q, flr_decay_q;
	logic [WIN_W-1:0]       win_len_q;

	// sequencer and datapath state
	state_t                    state_q;
	logic signed [LP_W-1:0]    x31_q, lp1_q, lp2_q;
	logic signed [BAND_W-1:0]  band_q;
	logic [POWER_W-1:0]        p_q, power_q, noise_q;
	logic [WIN_W-1:0]          win_cnt_q;
	logic [ACC_W-1:0]          acc_q;
	logic [1:0]                mix_idx_q;
	logic                      mix_flr_q;    // 1: floor relaxation, 0: power smoothing
	logic [DEN_W-1:0]          rem_q, den_q;
	logic [GAIN_BITS-1:0]      gain_q;
	logic [DCNT_W-1:0]         div_cnt_q;
	logic                      m_tvalid_q;
	logic [SAMPLE_WIDTH-1:0]   out_q;

	// multiplier
	logic signed [A_W-1:0]     mul_a;
	logic signed [B_W-1:0]     mul_b;
	logic                      mul_en;
	logic signed [P_W-1:0]     prod;
	logic [P_W-1:0]            prod_u;

	// combinational helpers
	logic signed [B23_W-1:0]   b23;
	logic [POWER_W-1:0]        mix_old, mix_now, mix_word;
	logic [COEFF_WIDTH:0]      mix_dec, mix_c;
	logic [HALF_W-1:0]         mix_half;
	logic [ACC_W-1:0]          mix_term, acc_sum;
	logic [POWER_W-1:0]        mix_res;
	logic signed [SUM_W-1:0]   lp_sum;
	logic signed [LP_W-1:0]    lp_sel, lp_clamped;
	logic [WIN_W-1:0]          win_next;
	logic [DEN_W:0]            rem_dbl;
	logic signed [P_W-1:0]     y_full;
	logic [SAMPLE_WIDTH-1:0]   y_sat;
	logic                      out_free;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = TD_W'(out_q);
	assign out_free  = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_coeff_q  <= COEFF_WIDTH'(bnfs_pkg::LOW_COEFF_RESET);
			high_coeff_q <= COEFF_WIDTH'(bnfs_pkg::HIGH_COEFF_RESET);
			pwr_decay_q  <= COEFF_WIDTH'(bnfs_pkg::PWR_DECAY_RESET);
			flr_decay_q  <= COEFF_WIDTH'(bnfs_pkg::FLR_DECAY_RESET);
			win_len_q    <= bnfs_pkg::WIN_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bnfs_pkg::REG_LOW_COEFF:  low_coeff_q  <= cfg_data[COEFF_WIDTH-1:0];
				bnfs_pkg::REG_HIGH_COEFF: high_coeff_q <= cfg_data[COEFF_WIDTH-1:0];
				bnfs_pkg::REG_PWR_DECAY:  pwr_decay_q  <= cfg_data[COEFF_WIDTH-1:0];
				bnfs_pkg::REG_FLR_DECAY:  flr_decay_q  <= cfg_data[COEFF_WIDTH-1:0];
				bnfs_pkg::REG_WIN_LEN:    win_len_q    <= cfg_data[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// --- operand selection ---
	assign b23 = B23_W'(band_q >>> 8);

	// mix(old, now, decay) = blend(old, decay) + blend(now, 1 - decay),
	// each blend split in a high and low 24-bit half: four products
	assign mix_old  = mix_flr_q ? noise_q : power_q;
	assign mix_now  = mix_flr_q ? power_q : p_q;
	assign mix_dec  = {1'b0, (mix_flr_q ? flr_decay_q : pwr_decay_q)};
	assign mix_c    = mix_idx_q[1] ? (C_ONE - mix_dec) : mix_dec;
	assign mix_word = mix_idx_q[1] ? mix_now : mix_old;
	assign mix_half = mix_idx_q[0] ? mix_word[HALF_W-1:0] : mix_word[POWER_W-1:HALF_W];

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		case (state_q)
			S_LP1M: begin
				mul_a = A_W'(x31_q) - A_W'(lp1_q);
				mul_b = B_W'(low_coeff_q);
			end
			S_LP2M: begin
				mul_a = A_W'(x31_q) - A_W'(lp2_q);
				mul_b = B_W'(high_coeff_q);
			end
			S_SQM: begin
				mul_a = A_W'(b23);
				mul_b = B_W'(b23);
			end
			S_MIXM: begin
				mul_a = A_W'(mix_half);
				mul_b = B_W'(mix_c);
			end
			S_OUTM: begin
				mul_a = A_W'(band_q);
				mul_b = B_W'(gain_q);
			end
			default: mul_en = 1'b0;
		endcase
	end

	bnfs_mul #(
		.B_W (B_W)
	) u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	assign prod_u = prod;

	// --- result paths ---
	// lowpass update: lp + floor(d * c / 2^CW), clamped to 32 bits
	assign lp_sel = (state_q == S_LP1A) ? lp1_q : lp2_q;
	assign lp_sum = SUM_W'(lp_sel) + SUM_W'(prod >>> COEFF_WIDTH);
	always_comb begin
		if (lp_sum > LP_MAX) begin
			lp_clamped = LP_W'(LP_MAX);
		end else if (lp_sum < LP_MIN) begin
			lp_clamped = LP_W'(LP_MIN);
		end else begin
			lp_clamped = LP_W'(lp_sum);
		end
	end

	// high half products carry a weight of 2^24, low half ones are floored
	assign mix_term = mix_idx_q[0] ? ACC_W'(prod_u >> COEFF_WIDTH)
	                               : ACC_W'(prod_u << (HALF_W - COEFF_WIDTH));
	assign acc_sum  = acc_q + mix_term;
	assign mix_res  = (acc_q[ACC_W-1:POWER_W] != '0) ? '1 : acc_q[POWER_W-1:0];

	assign win_next = win_cnt_q + WIN_W'(1);
	assign rem_dbl  = {rem_q, 1'b0};

	assign y_full = prod >>> OUT_SH;
	always_comb begin
		if (y_full > Y_MAX) begin
			y_sat = SAMPLE_WIDTH'(Y_MAX);
		end else if (y_full < Y_MIN) begin
			y_sat = SAMPLE_WIDTH'(Y_MIN);
		end else begin
			y_sat = SAMPLE_WIDTH'(y_full);
		end
	end

	// --- sequencer ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			x31_q      <= '0;
			lp1_q      <= '0;
			lp2_q      <= '0;
			band_q     <= '0;
			p_q        <= '0;
			power_q    <= '0;
			noise_q    <= bnfs_pkg::FLOOR_RESET;
			win_cnt_q  <= '0;
			acc_q      <= '0;
			mix_idx_q  <= '0;
			mix_flr_q  <= 1'b0;
			rem_q      <= '0;
			den_q      <= '0;
			gain_q     <= '0;
			div_cnt_q  <= '0;
			m_tvalid_q <= 1'b0;
			out_q      <= '0;
		end else begin
			// S_OUTA handles the output register itself
			if (m_tvalid_q && m_tready && state_q != S_OUTA) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						// sample scaled to Q1.31
						x31_q   <= LP_W'($signed(s_tdata[SAMPLE_WIDTH-1:0])) <<<
						           (LP_W - SAMPLE_WIDTH);
						state_q <= S_LP1M;
					end
				end
				S_LP1M: state_q <= S_LP1A;
				S_LP1A: begin
					lp1_q   <= lp_clamped;
					state_q <= S_LP2M;
				end
				S_LP2M: state_q <= S_LP2A;
				S_LP2A: begin
					lp2_q   <= lp_clamped;
					state_q <= S_BAND;
				end
				S_BAND: begin
					band_q  <= BAND_W'(lp1_q) - BAND_W'(lp2_q);
					state_q <= S_SQM;
				end
				S_SQM: state_q <= S_SQA;
				S_SQA: begin
					// only the most negative shifted band value squares past 48 bits
					p_q       <= (prod_u[P_W-1:POWER_W] != '0) ? '1 : prod_u[POWER_W-1:0];
					acc_q     <= '0;
					mix_idx_q <= '0;
					mix_flr_q <= 1'b0;
					state_q   <= S_MIXM;
				end
				S_MIXM: state_q <= S_MIXA;
				S_MIXA: begin
					acc_q     <= acc_sum;
					mix_idx_q <= mix_idx_q + 2'd1;
					state_q   <= (mix_idx_q == 2'd3) ? S_MIXE : S_MIXM;
				end
				S_MIXE: begin
					if (mix_flr_q) begin
						noise_q <= mix_res;
						state_q <= S_DIVI;
					end else begin
						power_q <= mix_res;
						state_q <= S_FLOOR;
					end
				end
				S_FLOOR: begin
					if (power_q < noise_q) begin
						noise_q <= power_q;
					end
					// also catches a window shortened below the count
					if (win_next >= win_len_q) begin
						win_cnt_q <= '0;
						acc_q     <= '0;
						mix_idx_q <= '0;
						mix_flr_q <= 1'b1;
						state_q   <= S_MIXM;
					end else begin
						win_cnt_q <= win_next;
						state_q   <= S_DIVI;
					end
				end
				S_DIVI: begin
					rem_q     <= (power_q > noise_q) ? DEN_W'(power_q - noise_q) : '0;
					den_q     <= DEN_W'(power_q) + DEN_W'(bnfs_pkg::POWER_EPS);
					gain_q    <= '0;
					div_cnt_q <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					// restoring step, one gain bit per cycle
					if (rem_dbl >= {1'b0, den_q}) begin
						rem_q  <= DEN_W'(rem_dbl - {1'b0, den_q});
						gain_q <= {gain_q[GAIN_BITS-2:0], 1'b1};
					end else begin
						rem_q  <= DEN_W'(rem_dbl);
						gain_q <= {gain_q[GAIN_BITS-2:0], 1'b0};
					end
					div_cnt_q <= div_cnt_q + DCNT_W'(1);
					if (div_cnt_q == DCNT_W'(GAIN_BITS - 1)) begin
						state_q <= S_OUTM;
					end
				end
				S_OUTM: state_q <= S_OUTA;
				S_OUTA: begin
					// hold the product until the output register frees up
					if (out_free) begin
						out_q      <= y_sat;
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// --- checks ---
	a_div_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < den_q))
		else $error("divider remainder not below divisor");

	a_floor_not_above_power: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLOOR) |=> (noise_q <= power_q))
		else $error("noise floor above power after minimum tracking");

	a_window_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLOOR) |=> (win_cnt_q < win_len_q || win_cnt_q == '0))
		else $error("window count left at or past window length");

	a_accept_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_LP1M && !s_tready))
		else $error("accepted item did not start the sequence");

endmodule

@@ rtl/bnfs_mul.sv @@
`timescale 1ns / 1ps
// Shared signed multiplier with registered product.
module bnfs_mul #(
	parameter int B_W = 26
) (
	input  logic                                       clk,
	input  logic                                       en,
	input  logic signed [bnfs_pkg::MUL_A_W-1:0]        a,
	input  logic signed [B_W-1:0]                      b,
	output logic signed [bnfs_pkg::MUL_A_W+B_W-1:0]    p
);

	always_ff @(posedge clk) begin
		if (en) begin
			p <= a * b;
		end
	end

endmodule

@@ verif/bandpass_noise_floor_suppressor_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the band noise floor suppressor: stimulus, predictor, checker.
module bandpass_noise_floor_suppressor_tb;
	import bnfs_pkg::*;

	localparam int SW   = SAMPLE_WIDTH_DEF;
	localparam int CW   = COEFF_WIDTH_DEF;
	localparam int TD_W = ((SW + 7) / 8) * 8;
	localparam int CFG_DW = (CW > WIN_W) ? CW : WIN_W;

	localparam int SAMPLE_MAX = (1 << (SW - 1)) - 1;
	localparam int SAMPLE_MIN = -(1 << (SW - 1));
	localparam logic [63:0] POWER_SAT = (64'd1 << POWER_W) - 64'd1;
	localparam logic [16:0] COEFF_UNITY = 17'h10000;

	// Settling time after the last result, before any register write.
	localparam int PIPE_SLACK = 64;
	// Longest quiet stretch of a correct run is the long output hold plus one item.
	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [TD_W-1:0] s_tdata = '0;       // [SW-1:0] sample_in
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [TD_W-1:0] m_tdata;            // [SW-1:0] sample_out
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DW-1:0] cfg_data = '0;

	bandpass_noise_floor_suppressor u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor: shadow copy of the registers and of the filter, power,
	// floor and window state, advanced once per accepted item.
	// ------------------------------------------------------------------
	logic [CW-1:0] low_coeff_sh, high_coeff_sh, pwr_decay_sh, flr_decay_sh;
	logic [WIN_W-1:0] win_len_sh;
	logic signed [LP_W-1:0] low_lp_sh, high_lp_sh;
	logic [POWER_W-1:0] power_sh, floor_sh;
	logic [WIN_W-1:0] win_count_sh;

	// Band samples still in flight, oldest first.
	logic [SW-1:0] band_out_q[$];

	int mismatch_count = 0;
	bit idle_on = 1'b1;       // random idle bursts on both sides
	bit hold_req = 1'b0;      // asks the receiver for one long hold-off

	// Stimulus shaping state.
	int burst_left = 0;
	int burst_kind = 0;
	int tone_period = 2;
	int tone_amp = 0;
	int tone_step = 0;

	function automatic logic signed [LP_W-1:0] lowpass_next(
		input logic signed [LP_W-1:0] lp, input longint x31, input logic [CW-1:0] c);
		longint diff, acc;
		diff = x31 - longint'(lp);
		// arithmetic shift of a signed product floors toward minus infinity
		acc = longint'(lp) + ((diff * longint'({1'b0, c})) >>> CW);
		if (acc > 64'sd2147483647)
			acc = 64'sd2147483647;
		else if (acc < -64'sd2147483648)
			acc = -64'sd2147483648;
		return acc[LP_W-1:0];
	endfunction

	// floor(a * c / 2^CW); the product stays below 2^64 for a < 2^48 and c <= 2^16
	function automatic logic [63:0] scale_frac(input logic [POWER_W-1:0] a,
		input logic [CW:0] c);
		logic [63:0] prod;
		prod = 64'(a) * 64'(c);
		return prod >> CW;
	endfunction

	function automatic logic [POWER_W-1:0] decay_toward(input logic [POWER_W-1:0] old_v,
		input logic [POWER_W-1:0] new_v, input logic [CW-1:0] decay);
		logic [63:0] sum;
		sum = scale_frac(old_v, {1'b0, decay}) + scale_frac(new_v, COEFF_UNITY - {1'b0, decay});
		if (sum > POWER_SAT)
			sum = POWER_SAT;
		return sum[POWER_W-1:0];
	endfunction

	function automatic logic [SW-1:0] predict_suppressed(input logic signed [SW-1:0] smp);
		longint x31, band, band_q23, scaled, y;
		logic [63:0] inst_power, num, den, gain;
		x31 = smp;
		x31 = x31 * (longint'(1) << (LP_W - SW));
		low_lp_sh = lowpass_next(low_lp_sh, x31, low_coeff_sh);
		high_lp_sh = lowpass_next(high_lp_sh, x31, high_coeff_sh);
		band = longint'(low_lp_sh) - longint'(high_lp_sh);

		band_q23 = band >>> 8;
		inst_power = 64'(band_q23 * band_q23);
		if (inst_power > POWER_SAT)
			inst_power = POWER_SAT;
		power_sh = decay_toward(power_sh, inst_power[POWER_W-1:0], pwr_decay_sh);

		// floor follows the minimum, then relaxes at the window end
		if (power_sh < floor_sh)
			floor_sh = power_sh;
		win_count_sh = win_count_sh + 1'b1;
		if (win_count_sh >= win_len_sh) begin
			win_count_sh = '0;
			floor_sh = decay_toward(floor_sh, power_sh, flr_decay_sh);
		end

		// numerator is always below the denominator, so the quotient fits in 16 bits
		num = (power_sh > floor_sh) ? 64'(power_sh - floor_sh) : 64'd0;
		den = 64'(power_sh) + 64'(POWER_EPS);
		gain = (num << GAIN_BITS) / den;

		scaled = (band * longint'(gain)) >>> GAIN_BITS;
		y = scaled >>> (LP_W - SW);
		if (y > longint'(SAMPLE_MAX))
			y = SAMPLE_MAX;
		else if (y < longint'(SAMPLE_MIN))
			y = SAMPLE_MIN;
		return y[SW-1:0];
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	// Offer one item and hold it until taken; the expectation is queued at the
	// accepting edge. tvalid stays high afterwards so back-to-back items do not
	// toggle it; end_stream drops it.
	task automatic send_sample(input logic signed [SW-1:0] smp);
		while (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= TD_W'(smp);
		do @(posedge clk); while (!s_tready);
		band_out_q = {band_out_q, predict_suppressed(smp)};
	endtask

	task automatic end_stream();
		s_tvalid <= 1'b0;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_LOW_COEFF:  low_coeff_sh = val[CW-1:0];
			REG_HIGH_COEFF: high_coeff_sh = val[CW-1:0];
			REG_PWR_DECAY:  pwr_decay_sh = val[CW-1:0];
			REG_FLR_DECAY:  flr_decay_sh = val[CW-1:0];
			REG_WIN_LEN:    win_len_sh = val[WIN_W-1:0];
			default: ;      // unused index: ignored by the block
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [CW-1:0] low_c, input logic [CW-1:0] high_c,
		input logic [CW-1:0] pwr_d, input logic [CW-1:0] flr_d, input logic [WIN_W-1:0] win);
		write_reg(REG_LOW_COEFF, low_c);
		write_reg(REG_HIGH_COEFF, high_c);
		write_reg(REG_PWR_DECAY, pwr_d);
		write_reg(REG_FLR_DECAY, flr_d);
		write_reg(REG_WIN_LEN, win);
	endtask

	// Wait until every result is back, then let the sequencer settle.
	task automatic drain_results();
		while (band_out_q.size() != 0) @(posedge clk);
		repeat (PIPE_SLACK) @(posedge clk);
	endtask

	// Audio-like stimulus: half the bursts are tones over a noise bed, the rest
	// low-level noise, silence, full-scale extremes and raw random words.
	function automatic logic signed [SW-1:0] next_audio_sample();
		int v;
		if (burst_left == 0) begin
			burst_kind = $urandom_range(0, 9);
			burst_left = $urandom_range(16, 120);
			tone_period = $urandom_range(2, 48);
			tone_amp = $urandom_range(1 << 12, SAMPLE_MAX - 8192);
		end
		burst_left--;
		tone_step++;
		case (burst_kind)
			0: v = int'($urandom);
			1: v = 0;
			2: v = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
			3, 4: v = int'($urandom_range(0, 8191)) - 4096;
			default: begin
				v = ((tone_step % tone_period) < tone_period / 2) ? tone_amp : -tone_amp;
				v += int'($urandom_range(0, 4095)) - 2048;
			end
		endcase
		return SW'(v);
	endfunction

	task automatic run_audio(input int n);
		repeat (n) send_sample(next_audio_sample());
		end_stream();
		drain_results();
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stalls of random length while idle_on, and one long
	// hold-off on request, counted here.
	// ------------------------------------------------------------------
	initial begin : receiver
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 3) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Checker: every accepted result against the oldest expectation.
	always @(posedge clk) begin : check_out
		logic [SW-1:0] want;
		if (m_tvalid && m_tready) begin
			if (band_out_q.size() == 0) begin
				report_mismatch($sformatf("sample_out %0d with nothing expected",
					$signed(m_tdata[SW-1:0])));
			end else begin
				want = band_out_q.pop_front();
				if (m_tdata[SW-1:0] !== want)
					report_mismatch($sformatf("sample_out got %0d expected %0d",
						$signed(m_tdata[SW-1:0]), $signed(want)));
			end
		end
	end

	// Watchdog: cycles in a row with no item, result or register write.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Reset values of registers and state, hit with full-scale steps.
	task automatic test_reset_state();
		send_sample(SW'(0));
		send_sample(SW'(SAMPLE_MAX));
		send_sample(SW'(SAMPLE_MAX));
		send_sample(SW'(SAMPLE_MIN));
		send_sample(SW'(SAMPLE_MIN));
		send_sample(SW'(-1));
		send_sample(SW'(1));
		send_sample(SW'(24'h555555));
		end_stream();
		drain_results();
	endtask

	// Writes to indexes past the last register must change nothing.
	task automatic test_unused_index();
		for (int idx = int'(REG_WIN_LEN) + 1; idx < (1 << CFG_IDX_W); idx++)
			write_reg(CFG_IDX_W'(idx), CFG_DW'($urandom));
		send_sample(SW'(24'hAAAAAA));
		send_sample(SW'(SAMPLE_MAX));
		end_stream();
		drain_results();
	endtask

	// Both lowpasses frozen at their current state and no power smoothing: the
	// band and the power stay constant from sample to sample.
	task automatic test_zero_power();
		apply_settings('0, '0, '0, FLR_DECAY_RESET[CW-1:0], WIN_LEN_RESET);
		send_sample(SW'(SAMPLE_MAX));
		send_sample(SW'(SAMPLE_MIN));
		send_sample(SW'(0));
		end_stream();
		drain_results();
	endtask

	// Zero window length relaxes the floor on every sample; coefficients at
	// the opposite extremes.
	task automatic test_window_zero();
		apply_settings({CW{1'b1}}, '0, '0, '0, '0);
		send_sample(SW'(SAMPLE_MAX));
		send_sample(SW'(SAMPLE_MIN));
		send_sample(SW'(SAMPLE_MAX));
		send_sample(SW'(0));
		end_stream();
		drain_results();
	endtask

	// Let the count run up, then shorten the window below it: the very next
	// sample must relax the floor.
	task automatic test_window_shortened();
		apply_settings(16'd30000, 16'd2000, 16'd50000, 16'd60000, {WIN_W{1'b1}});
		send_sample(SW'(SAMPLE_MAX));
		send_sample(SW'(SAMPLE_MIN));
		send_sample(SW'(SAMPLE_MAX));
		send_sample(SW'(SAMPLE_MIN));
		send_sample(SW'(SAMPLE_MAX));
		end_stream();
		drain_results();
		write_reg(REG_WIN_LEN, 16'd2);
		send_sample(SW'(SAMPLE_MIN));
		send_sample(SW'(SAMPLE_MAX));
		end_stream();
		drain_results();
	endtask

	// Audio through several register settings: reset values, a useful band,
	// random coefficients with mostly short windows and both sets of extremes.
	task automatic test_settings_sweep();
		apply_settings(LOW_COEFF_RESET[CW-1:0], HIGH_COEFF_RESET[CW-1:0],
			PWR_DECAY_RESET[CW-1:0], FLR_DECAY_RESET[CW-1:0], WIN_LEN_RESET);
		run_audio(200);
		apply_settings(16'd30000, 16'd2000, 16'd60000, 16'd64000, 16'd50);
		run_audio(500);
		repeat (3) begin
			apply_settings(CW'($urandom_range(0, 65535)), CW'($urandom_range(0, 65535)),
				CW'($urandom_range(0, 65535)), CW'($urandom_range(0, 65535)),
				WIN_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
				                                   : $urandom_range(0, 64)));
			run_audio(170);
		end
		apply_settings({CW{1'b1}}, '0, {CW{1'b1}}, '0, 16'd1);
		run_audio(150);
		apply_settings('0, {CW{1'b1}}, '0, {CW{1'b1}}, {WIN_W{1'b1}});
		run_audio(150);
	endtask

	// Receiver holds off for a long stretch while items keep coming: one
	// result parks in the output register, the next finishes behind it, and
	// the input must stall until the hold ends.
	task automatic test_output_backpressure();
		apply_settings(16'd20000, 16'd1500, 16'd62000, 16'd65000, 16'd8);
		hold_req = 1'b1;
		run_audio(40);
	endtask

	// Last part: no idling on either side, items back to back.
	task automatic test_streaming_no_idle();
		idle_on = 1'b0;
		apply_settings(16'd40000, 16'd3000, 16'd58000, 16'd63000, 16'd32);
		run_audio(300);
	endtask

	initial begin
		low_coeff_sh = LOW_COEFF_RESET[CW-1:0];
		high_coeff_sh = HIGH_COEFF_RESET[CW-1:0];
		pwr_decay_sh = PWR_DECAY_RESET[CW-1:0];
		flr_decay_sh = FLR_DECAY_RESET[CW-1:0];
		win_len_sh = WIN_LEN_RESET;
		low_lp_sh = '0;
		high_lp_sh = '0;
		power_sh = '0;
		floor_sh = FLOOR_RESET;
		win_count_sh = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_state();
		test_unused_index();
		test_zero_power();
		test_window_zero();
		test_window_shortened();
		test_settings_sweep();
		test_output_backpressure();
		test_streaming_no_idle();

		if (band_out_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", band_out_q.size()));
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/bnfs_pkg.sv
rtl/bnfs_mul.sv
rtl/bandpass_noise_floor_suppressor.sv
verif/bandpass_noise_floor_suppressor_tb.sv
